// ===== sv/gla_pkg.sv =====
// ----------------------------------------------------------------------------
// gla_pkg
// Shared widths, codes and types for the gate layer assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package gla_pkg;

   localparam int unsigned QUBITS_DEFAULT = 128;
   localparam int unsigned QUBIT_IDX_W    = 7;
   localparam int unsigned LAYER_W        = 15;
   localparam int unsigned COUNT_W        = 32;

   localparam logic [LAYER_W-1:0] LAYER_MAX = {LAYER_W{1'b1}};

   typedef logic [1:0] strategy_type;
   typedef logic [1:0] status_type;

   localparam strategy_type STRAT_SERIAL   = 2'd0;
   localparam strategy_type STRAT_DISJOINT = 2'd1;
   localparam strategy_type STRAT_PAIRS    = 2'd2;
   localparam strategy_type STRAT_TRIANGLE = 2'd3;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NONUNIT   = 2'd1;
   localparam status_type STATUS_OPERANDS  = 2'd2;
   localparam status_type STATUS_OVERFLOW  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/gate_layer_assigner.sv =====
// ----------------------------------------------------------------------------
// gate_layer_assigner
// Assigns a layer index to each gate of a stream under a selectable strategy.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-----------------------------
//  req_     | in        | req_tvalid/req_tready  | tuser action, tdata gate
//  rsp_     | out       | rsp_tvalid/rsp_tready  | tuser status, tdata layers
//  csr_     | in        | csr_valid/csr_ready    | strategy register
//
//  One request per cycle sustained while rsp_tready is high; each taken request
//  is registered in the input stage, then in the result register.
//  The input stage is there for the registered reads of the per-qubit layer ram;
//  writes of the request ahead are forwarded into the following read.
//  Reset is synchronous: per-entry valid bits drop at once.
//  When rsp_tready is low the result register and input stage hold, and
//  req_tready falls once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module gate_layer_assigner #(
   parameter int unsigned QUBITS = gla_pkg::QUBITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // [0] action
   // [0] has_control, [7:1] control_qubit, [14:8] target_qubit,
   // [15] is_unitary, [16] extra_operands
   input  wire logic [23:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // [1:0] status
   // [14:0] layer, [15] opened_layer, [30:16] layer_total,
   // [62:31] single_gates, [94:63] two_qubit_gates
   output logic [95:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_data
);
   import gla_pkg::*;

   localparam int unsigned IDX_SPAN = 2 ** QUBIT_IDX_W;
   localparam int unsigned DEPTH    = (QUBITS < IDX_SPAN) ? QUBITS : IDX_SPAN;
   localparam int unsigned QW       = $clog2(DEPTH);

   // qubit index folding, resolved at elaboration
   logic [QW-1:0] wrap_lut [IDX_SPAN];
   for (genvar gi = 0; gi < IDX_SPAN; gi++) begin : g_wrap
      localparam int unsigned WRAPPED = gi % QUBITS;
      assign wrap_lut[gi] = QW'(WRAPPED);
   end

   // ---------------- configuration ----------------
   strategy_type strategy_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= STRAT_SERIAL;
      end else if (csr_valid) begin
         strategy_ff <= csr_data;
      end
   end

   // ---------------- input stage ----------------
   logic          req_accept;
   logic          s1_advance;
   logic [QW-1:0] ctl_in;
   logic [QW-1:0] tgt_in;

   logic          s1_valid_ff;
   logic          s1_clear_ff;
   logic          s1_two_ff;
   logic [QW-1:0] s1_ctl_ff;
   logic [QW-1:0] s1_tgt_ff;
   logic          s1_unitary_ff;
   logic          s1_extra_ff;

   logic               hit_at_ff, hit_ac_ff, hit_bt_ff, hit_bc_ff;
   logic [LAYER_W-1:0] fwd_data_ff;

   assign ctl_in     = wrap_lut[req_tdata[7:1]];
   assign tgt_in     = wrap_lut[req_tdata[14:8]];
   assign s1_advance = s1_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // ---------------- state ----------------
   logic [LAYER_W-1:0] layer_count_ff;
   logic               gate_odd_ff;
   logic [COUNT_W-1:0] single_count_ff;
   logic [COUNT_W-1:0] pair_count_ff;
   logic [QW-1:0]      tri_member_ff [3];
   logic [1:0]         tri_fill_ff;
   logic [DEPTH-1:0]   valid_a_ff;
   logic [DEPTH-1:0]   valid_b_ff;

   // ---------------- layer rams ----------------
   // copy a is written at the target, copy b at the control; a qubit's
   // layer only grows, so the newer of the two copies is the larger one
   logic               wr_en_a, wr_en_b;
   logic [LAYER_W-1:0] a_t_rd, a_c_rd, b_t_rd, b_c_rd;
   logic [LAYER_W-1:0] need_c;

   gla_layer_ram #(.DEPTH(DEPTH)) u_ram_a (
      .clock     (clock),
      .wr_en     (wr_en_a),
      .wr_addr   (s1_tgt_ff),
      .wr_data   (need_c),
      .rd_en     (req_accept),
      .rd_addr_a (tgt_in),
      .rd_addr_b (ctl_in),
      .rd_data_a (a_t_rd),
      .rd_data_b (a_c_rd)
   );

   gla_layer_ram #(.DEPTH(DEPTH)) u_ram_b (
      .clock     (clock),
      .wr_en     (wr_en_b),
      .wr_addr   (s1_ctl_ff),
      .wr_data   (need_c),
      .rd_en     (req_accept),
      .rd_addr_a (tgt_in),
      .rd_addr_b (ctl_in),
      .rd_data_a (b_t_rd),
      .rd_data_b (b_c_rd)
   );

   // ---------------- compute ----------------
   logic               gate_ok;
   logic [LAYER_W-1:0] a_t, a_c, b_t, b_c;
   logic [LAYER_W:0]   inc_ta, inc_tb, inc_ca, inc_cb, inc_t, inc_c, inc_max;
   logic [LAYER_W:0]   need;
   logic               opened;
   status_type         status;
   logic [LAYER_W-1:0] layer_count_in;
   logic               lc_zero;
   logic [LAYER_W-1:0] lc_less;

   logic [1:0]         fill_eff;
   logic               ct, tt, tgt_new, open3;
   logic [1:0]         add;
   logic [2:0]         fill_sum;
   logic [1:0]         pos_t;
   logic [QW-1:0]      tri_member_in [3];
   logic [1:0]         tri_fill_in;

   assign gate_ok = s1_unitary_ff && !s1_extra_ff;
   assign lc_zero = (layer_count_ff == '0);
   assign lc_less = layer_count_ff - LAYER_W'(1);

   assign a_t = hit_at_ff ? fwd_data_ff : a_t_rd;
   assign a_c = hit_ac_ff ? fwd_data_ff : a_c_rd;
   assign b_t = hit_bt_ff ? fwd_data_ff : b_t_rd;
   assign b_c = hit_bc_ff ? fwd_data_ff : b_c_rd;

   // a qubit never written reads as minus one, so its successor is zero
   assign inc_ta  = valid_a_ff[s1_tgt_ff] ? ({1'b0, a_t} + 1'b1) : '0;
   assign inc_tb  = valid_b_ff[s1_tgt_ff] ? ({1'b0, b_t} + 1'b1) : '0;
   assign inc_ca  = valid_a_ff[s1_ctl_ff] ? ({1'b0, a_c} + 1'b1) : '0;
   assign inc_cb  = valid_b_ff[s1_ctl_ff] ? ({1'b0, b_c} + 1'b1) : '0;
   assign inc_t   = (inc_ta > inc_tb) ? inc_ta : inc_tb;
   assign inc_c   = (inc_ca > inc_cb) ? inc_ca : inc_cb;
   assign inc_max = (s1_two_ff && (inc_c > inc_t)) ? inc_c : inc_t;

   // triangle membership update
   always_comb begin
      fill_eff = lc_zero ? 2'd0 : tri_fill_ff;
      ct = ((fill_eff >= 2'd1) && (tri_member_ff[0] == s1_ctl_ff))
         || ((fill_eff >= 2'd2) && (tri_member_ff[1] == s1_ctl_ff))
         || ((fill_eff == 2'd3) && (tri_member_ff[2] == s1_ctl_ff));
      tt = ((fill_eff >= 2'd1) && (tri_member_ff[0] == s1_tgt_ff))
         || ((fill_eff >= 2'd2) && (tri_member_ff[1] == s1_tgt_ff))
         || ((fill_eff == 2'd3) && (tri_member_ff[2] == s1_tgt_ff));
      tgt_new  = !tt && (s1_tgt_ff != s1_ctl_ff);
      add      = {1'b0, !ct} + {1'b0, tgt_new};
      fill_sum = {1'b0, fill_eff} + {1'b0, add};
      pos_t    = fill_eff + {1'b0, !ct};
      tri_member_in = tri_member_ff;
      tri_fill_in   = fill_eff;
      open3         = lc_zero;
      if (s1_two_ff) begin
         if (fill_sum <= 3'd3) begin
            for (int i = 0; i < 3; i++) begin
               if (!ct && (fill_eff == 2'(i))) begin
                  tri_member_in[i] = s1_ctl_ff;
               end
               if (tgt_new && (pos_t == 2'(i))) begin
                  tri_member_in[i] = s1_tgt_ff;
               end
            end
            tri_fill_in = fill_sum[1:0];
         end else begin
            // too many qubits: start a new layer with this gate's pair
            tri_member_in[0] = s1_ctl_ff;
            tri_member_in[1] = s1_tgt_ff;
            tri_fill_in      = (s1_tgt_ff != s1_ctl_ff) ? 2'd2 : 2'd1;
            open3            = 1'b1;
         end
      end
   end

   always_comb begin
      need   = {1'b0, layer_count_ff};
      opened = 1'b1;
      unique case (strategy_ff)
         STRAT_SERIAL: begin
            need   = {1'b0, layer_count_ff};
            opened = 1'b1;
         end
         STRAT_DISJOINT: begin
            need   = inc_max;
            opened = (inc_max >= {1'b0, layer_count_ff});
         end
         STRAT_PAIRS: begin
            opened = !gate_odd_ff || lc_zero;
            need   = opened ? {1'b0, layer_count_ff} : {1'b0, lc_less};
         end
         STRAT_TRIANGLE: begin
            opened = open3;
            need   = opened ? {1'b0, layer_count_ff} : {1'b0, lc_less};
         end
         default: begin
            need   = {1'b0, layer_count_ff};
            opened = 1'b1;
         end
      endcase

      status = STATUS_OK;
      need_c = need[LAYER_W-1:0];
      if (need >= {1'b0, LAYER_MAX}) begin
         need_c = LAYER_MAX;
         status = STATUS_OVERFLOW;
      end

      layer_count_in = layer_count_ff;
      if (opened) begin
         layer_count_in = (need_c == LAYER_MAX) ? LAYER_MAX : need_c + LAYER_W'(1);
      end
   end

   assign wr_en_a = s1_advance && !s1_clear_ff && gate_ok && (strategy_ff == STRAT_DISJOINT);
   assign wr_en_b = wr_en_a && s1_two_ff;

   // ---------------- input stage registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_clear_ff   <= req_tuser;
         s1_two_ff     <= req_tdata[0];
         s1_ctl_ff     <= ctl_in;
         s1_tgt_ff     <= tgt_in;
         s1_unitary_ff <= req_tdata[15];
         s1_extra_ff   <= req_tdata[16];
         // forward the write going on in this same cycle
         hit_at_ff     <= wr_en_a && (tgt_in == s1_tgt_ff);
         hit_ac_ff     <= wr_en_a && (ctl_in == s1_tgt_ff);
         hit_bt_ff     <= wr_en_b && (tgt_in == s1_ctl_ff);
         hit_bc_ff     <= wr_en_b && (ctl_in == s1_ctl_ff);
         fwd_data_ff   <= need_c;
      end
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff  <= '0;
         gate_odd_ff     <= 1'b0;
         single_count_ff <= '0;
         pair_count_ff   <= '0;
         tri_fill_ff     <= 2'd0;
         valid_a_ff      <= '0;
         valid_b_ff      <= '0;
      end else if (s1_advance) begin
         if (s1_clear_ff) begin
            layer_count_ff  <= '0;
            gate_odd_ff     <= 1'b0;
            single_count_ff <= '0;
            pair_count_ff   <= '0;
            tri_fill_ff     <= 2'd0;
            valid_a_ff      <= '0;
            valid_b_ff      <= '0;
         end else if (gate_ok) begin
            layer_count_ff <= layer_count_in;
            gate_odd_ff    <= !gate_odd_ff;
            if (s1_two_ff) begin
               pair_count_ff <= pair_count_ff + COUNT_W'(1);
            end else begin
               single_count_ff <= single_count_ff + COUNT_W'(1);
            end
            if (strategy_ff == STRAT_TRIANGLE) begin
               tri_fill_ff <= tri_fill_in;
            end
            if (wr_en_a) begin
               valid_a_ff[s1_tgt_ff] <= 1'b1;
            end
            if (wr_en_b) begin
               valid_b_ff[s1_ctl_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && !s1_clear_ff && gate_ok && (strategy_ff == STRAT_TRIANGLE)) begin
         tri_member_ff <= tri_member_in;
      end
   end

   // ---------------- result register ----------------
   logic               rsp_tvalid_ff;
   status_type         rsp_status_ff;
   logic [LAYER_W-1:0] rsp_layer_ff;
   logic               rsp_opened_ff;
   logic [LAYER_W-1:0] rsp_total_ff;
   logic [COUNT_W-1:0] rsp_single_ff;
   logic [COUNT_W-1:0] rsp_pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         if (s1_clear_ff) begin
            rsp_status_ff <= STATUS_OK;
            rsp_layer_ff  <= '0;
            rsp_opened_ff <= 1'b0;
            rsp_total_ff  <= '0;
            rsp_single_ff <= '0;
            rsp_pair_ff   <= '0;
         end else if (!gate_ok) begin
            rsp_status_ff <= s1_unitary_ff ? STATUS_OPERANDS : STATUS_NONUNIT;
            rsp_layer_ff  <= '0;
            rsp_opened_ff <= 1'b0;
            rsp_total_ff  <= layer_count_ff;
            rsp_single_ff <= single_count_ff;
            rsp_pair_ff   <= pair_count_ff;
         end else begin
            rsp_status_ff <= status;
            rsp_layer_ff  <= need_c;
            rsp_opened_ff <= opened;
            rsp_total_ff  <= layer_count_in;
            rsp_single_ff <= s1_two_ff ? single_count_ff : single_count_ff + COUNT_W'(1);
            rsp_pair_ff   <= s1_two_ff ? pair_count_ff + COUNT_W'(1) : pair_count_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_pair_ff, rsp_single_ff, rsp_total_ff,
                        rsp_opened_ff, rsp_layer_ff};

endmodule

`default_nettype wire

// ===== sv/gla_layer_ram.sv =====
// ----------------------------------------------------------------------------
// gla_layer_ram
// Per-qubit last-layer store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module gla_layer_ram #(
   parameter int unsigned DEPTH = gla_pkg::QUBITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  wire logic [gla_pkg::LAYER_W-1:0]     wr_data,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]        rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0]        rd_addr_b,
   output logic      [gla_pkg::LAYER_W-1:0]     rd_data_a,
   output logic      [gla_pkg::LAYER_W-1:0]     rd_data_b
);
   import gla_pkg::*;

   logic [LAYER_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire
